// ===== sv/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Types, codes and sizes shared by the cooperative task scheduler modules.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int MAX_TASKS    = 8;
	localparam int RESULT_LIMIT = 8;
	localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W        = $clog2(MAX_TASKS + 1);
	localparam int N_W          = $clog2(RESULT_LIMIT + 1);
	localparam int CMP_W        = (CNT_W > 3) ? CNT_W : 3;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ADD  = 2'd1;
	localparam logic [1:0] CMD_DEL  = 2'd2;
	localparam logic [1:0] CMD_DISP = 2'd3;

	localparam logic [2:0] STAT_DONE    = 3'd0;
	localparam logic [2:0] STAT_DUE     = 3'd1;
	localparam logic [2:0] STAT_NONE    = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_NO_SLOT = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  task_tag;
		logic [23:0] start_delay;
		logic [23:0] repeat_period;
		logic [2:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] due_tag;
		logic [2:0] due_slot;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [7:0]  tag;
		logic [23:0] delay;
		logic [23:0] period;
		logic [7:0]  runs;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_SHIFT,
		S_DRD,
		S_DEV
	} state_t;

	function automatic result_t mk_result(logic [2:0] status, logic [7:0] tag,
	                                      logic [2:0] slot, logic last);
		result_t r;
		r.status   = status;
		r.due_tag  = tag;
		r.due_slot = slot;
		r.last     = last;
		return r;
	endfunction

endpackage

// ===== sv/cts_table.sv =====
// ----------------------------------------------------------------------------
// cts_table
// Task table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cts_table (
	input  logic              clk,
	input  cts_pkg::mem_req_t req,
	output cts_pkg::entry_t   rdata
);
	import cts_pkg::*;

	entry_t mem [MAX_TASKS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/cts_ctrl.sv =====
// ----------------------------------------------------------------------------
// cts_ctrl
// Command sequencer: walks the task table for tick, delete and dispatch,
// keeps the task count and drives the result word.
// ----------------------------------------------------------------------------
module cts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cts_pkg::cmd_t     item,
	output logic              busy,
	output cts_pkg::result_t  result,
	output logic              strobe,
	output cts_pkg::mem_req_t req,
	input  cts_pkg::entry_t   rdata
);
	import cts_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] ridx_q, ridx_d;
	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic [N_W-1:0]   n_q, n_d;
	logic             rv_s1, rv_d;
	logic [IDX_W-1:0] widx_s1, widx_d;
	result_t          hold_q, hold_d;
	logic             hold_v_q, hold_v_d;
	logic             ret_q, ret_d;
	cmd_t             item_q;
	result_t          out_q, out_d;
	logic             strobe_q, strobe_d;
	logic [CNT_W-1:0] rm1;
	logic             rd_more;
	entry_t           upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rv_s1    <= 1'b0;
			hold_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			rv_s1    <= rv_d;
			hold_v_q <= hold_v_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		ridx_q  <= ridx_d;
		ptr_q   <= ptr_d;
		n_q     <= n_d;
		widx_s1 <= widx_d;
		hold_q  <= hold_d;
		ret_q   <= ret_d;
		out_q   <= out_d;
		if (start && state_q == S_IDLE) begin
			item_q <= item;
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		ridx_d   = ridx_q;
		ptr_d    = ptr_q;
		n_d      = n_q;
		rv_d     = 1'b0;
		widx_d   = widx_s1;
		hold_d   = hold_q;
		hold_v_d = hold_v_q;
		ret_d    = ret_q;
		out_d    = out_q;
		strobe_d = 1'b0;
		req      = '0;
		rm1      = ridx_q - CNT_W'(1);
		rd_more  = (ridx_q < count_q);
		upd      = rdata;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (item.command)
						CMD_TICK: begin
							ridx_d  = '0;
							state_d = S_TICK;
						end
						CMD_ADD: begin
							strobe_d = 1'b1;
							if (count_q < CNT_W'(MAX_TASKS)) begin
								req.we           = 1'b1;
								req.waddr        = count_q[IDX_W-1:0];
								req.wdata.tag    = item.task_tag;
								req.wdata.delay  = item.start_delay;
								req.wdata.period = item.repeat_period;
								req.wdata.runs   = '0;
								count_d = count_q + CNT_W'(1);
								out_d = mk_result(STAT_DONE, 8'd0, 3'(count_q), 1'b1);
							end else begin
								out_d = mk_result(STAT_FULL, 8'd0, 3'd0, 1'b1);
							end
						end
						CMD_DEL: begin
							if (CMP_W'(item.slot) < CMP_W'(count_q)) begin
								ridx_d  = CNT_W'(item.slot) + CNT_W'(1);
								ret_d   = 1'b0;
								state_d = S_SHIFT;
							end else begin
								strobe_d = 1'b1;
								out_d = mk_result(STAT_NO_SLOT, 8'd0, 3'd0, 1'b1);
							end
						end
						CMD_DISP: begin
							ptr_d    = '0;
							n_d      = '0;
							hold_v_d = 1'b0;
							state_d  = S_DRD;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end

			S_TICK: begin
				if (rd_more) begin
					req.raddr = ridx_q[IDX_W-1:0];
					ridx_d    = ridx_q + CNT_W'(1);
					rv_d      = 1'b1;
					widx_d    = ridx_q[IDX_W-1:0];
				end
				if (rv_s1) begin
					if (rdata.delay != '0) begin
						upd.delay = rdata.delay - 24'd1;
					end else begin
						if (rdata.runs != 8'hFF) begin
							upd.runs = rdata.runs + 8'd1;
						end
						if (rdata.period != '0) begin
							upd.delay = rdata.period;
						end
					end
					req.we    = 1'b1;
					req.waddr = widx_s1;
					req.wdata = upd;
				end
				if (!rd_more && !rv_s1) begin
					strobe_d = 1'b1;
					out_d    = mk_result(STAT_DONE, 8'd0, 3'd0, 1'b1);
					state_d  = S_IDLE;
				end
			end

			S_SHIFT: begin
				if (rd_more) begin
					req.raddr = ridx_q[IDX_W-1:0];
					ridx_d    = ridx_q + CNT_W'(1);
					rv_d      = 1'b1;
					widx_d    = rm1[IDX_W-1:0];
				end
				if (rv_s1) begin
					req.we    = 1'b1;
					req.waddr = widx_s1;
					req.wdata = rdata;
				end
				if (!rd_more && !rv_s1) begin
					count_d = count_q - CNT_W'(1);
					if (ret_q) begin
						state_d = S_DRD;
					end else begin
						strobe_d = 1'b1;
						out_d    = mk_result(STAT_DONE, 8'd0, item_q.slot, 1'b1);
						state_d  = S_IDLE;
					end
				end
			end

			S_DRD: begin
				if (ptr_q < count_q && n_q < N_W'(RESULT_LIMIT)) begin
					req.raddr = ptr_q[IDX_W-1:0];
					state_d   = S_DEV;
				end else begin
					strobe_d = 1'b1;
					if (hold_v_q) begin
						out_d      = hold_q;
						out_d.last = 1'b1;
					end else begin
						out_d = mk_result(STAT_NONE, 8'd0, 3'd0, 1'b1);
					end
					state_d = S_IDLE;
				end
			end

			S_DEV: begin
				if (rdata.runs != '0) begin
					if (hold_v_q) begin
						strobe_d = 1'b1;
						out_d    = hold_q;
					end
					hold_d    = mk_result(STAT_DUE, rdata.tag, 3'(ptr_q), 1'b0);
					hold_v_d  = 1'b1;
					n_d       = n_q + N_W'(1);
					upd.runs  = rdata.runs - 8'd1;
					req.we    = 1'b1;
					req.waddr = ptr_q[IDX_W-1:0];
					req.wdata = upd;
					if (rdata.period == '0) begin
						ridx_d  = ptr_q + CNT_W'(1);
						ret_d   = 1'b1;
						state_d = S_SHIFT;
					end else begin
						ptr_d   = ptr_q + CNT_W'(1);
						state_d = S_DRD;
					end
				end else begin
					ptr_d   = ptr_q + CNT_W'(1);
					state_d = S_DRD;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign result = out_q;
	assign strobe = strobe_q;

endmodule

// ===== sv/cooperative_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// cooperative_task_scheduler
// Time-triggered task table with tick, add, delete and dispatch commands.
// ----------------------------------------------------------------------------
// Add and an out-of-range delete answer in the cycle after accept; tick,
// delete and dispatch walk the table, and their run time grows with the
// entries read and moved. The single read port of the memory sets this.
// One command at a time, results never stall; reset clears count and control.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cts_pkg::cmd_t    item,
	output cts_pkg::result_t result,
	output logic             strobe
);
	import cts_pkg::*;

	mem_req_t req;
	entry_t   rdata;

	cts_table u_table (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	cts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.result (result),
		.strobe (strobe),
		.req    (req),
		.rdata  (rdata)
	);

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || (strobe && result.last)))
		else $error("accepted word neither started work nor answered");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> busy)
		else $error("non-final result while idle");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.status == STAT_NONE) |-> result.last)
		else $error("nothing-due result not final");

endmodule

// ===== bench/task_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_table_checker
// Watches the command and result channels of the task scheduler, keeps its
// own copy of the task table, works out the words each accepted command must
// return and compares every returned word field by field, in order.
// ----------------------------------------------------------------------------
module task_table_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  cts_pkg::cmd_t    item,
	input  cts_pkg::result_t result,
	input  logic             strobe,
	output int               errors,
	output int               pending
);
	import cts_pkg::*;

	entry_t      task_table[MAX_TASKS];
	int unsigned live_count  = 0;
	result_t     due_words[$];
	result_t     want;
	int          error_total = 0;

	task automatic report(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_total++;
	endtask

	task automatic remove_entry(input int unsigned pos);
		for (int unsigned k = pos; k + 1 < live_count; k++)
			task_table[k] = task_table[k + 1];
		live_count--;
	endtask

	task automatic predict(input cmd_t w);
		result_t     burst[RESULT_LIMIT];
		int          n;
		int unsigned i;
		n = 0;
		case (w.command)
		CMD_TICK: begin
			for (i = 0; i < live_count; i++) begin
				if (task_table[i].delay != 24'd0) begin
					task_table[i].delay--;
				end else begin
					if (task_table[i].runs != 8'hFF)
						task_table[i].runs++;
					if (task_table[i].period != 24'd0)
						task_table[i].delay = task_table[i].period;
				end
			end
			burst[0] = result_t'{STAT_DONE, 8'h00, 3'd0, 1'b0};
			n = 1;
		end
		CMD_ADD: begin
			if (live_count < MAX_TASKS) begin
				task_table[live_count] = entry_t'{w.task_tag, w.start_delay,
				                                  w.repeat_period, 8'h00};
				burst[0] = result_t'{STAT_DONE, 8'h00, 3'(live_count), 1'b0};
				live_count++;
			end else begin
				burst[0] = result_t'{STAT_FULL, 8'h00, 3'd0, 1'b0};
			end
			n = 1;
		end
		CMD_DEL: begin
			if (w.slot < live_count) begin
				remove_entry(w.slot);
				burst[0] = result_t'{STAT_DONE, 8'h00, w.slot, 1'b0};
			end else begin
				burst[0] = result_t'{STAT_NO_SLOT, 8'h00, 3'd0, 1'b0};
			end
			n = 1;
		end
		default: begin
			i = 0;
			while (i < live_count && n < RESULT_LIMIT) begin
				if (task_table[i].runs != 8'h00) begin
					burst[n] = result_t'{STAT_DUE, task_table[i].tag, 3'(i), 1'b0};
					n++;
					task_table[i].runs--;
					// one-shot leaves at once; re-examine the slot it vacated
					if (task_table[i].period == 24'd0) begin
						remove_entry(i);
						continue;
					end
				end
				i++;
			end
			if (n == 0) begin
				burst[0] = result_t'{STAT_NONE, 8'h00, 3'd0, 1'b0};
				n = 1;
			end
		end
		endcase
		burst[n - 1].last = 1'b1;
		for (int k = 0; k < n; k++)
			due_words.push_back(burst[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_count = 0;
			due_words.delete();
			errors  <= error_total;
			pending <= 0;
		end else begin
			if (strobe) begin
				if (due_words.size() == 0) begin
					report($sformatf("unexpected word: status %0d tag %02h slot %0d last %0b",
					                 result.status, result.due_tag, result.due_slot,
					                 result.last));
				end else begin
					want = due_words.pop_front();
					if (result.status !== want.status)
						report($sformatf("status %0d, expected %0d",
						                 result.status, want.status));
					if (result.due_tag !== want.due_tag)
						report($sformatf("due_tag %02h, expected %02h",
						                 result.due_tag, want.due_tag));
					if (result.due_slot !== want.due_slot)
						report($sformatf("due_slot %0d, expected %0d",
						                 result.due_slot, want.due_slot));
					if (result.last !== want.last)
						report($sformatf("last %0b, expected %0b",
						                 result.last, want.last));
				end
			end
			if (start && !busy)
				predict(item);
			errors  <= error_total;
			pending <= due_words.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the task scheduler with a directed opening (empty table, full table,
// eight due tasks, chained one-shot removal, bad slots), then random command
// mixes under changing sender gaps. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import cts_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 120;
	localparam int PHASE_WORDS  = 119;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    item   = '0;
	logic    busy;
	result_t result;
	logic    strobe;
	int      mismatches;
	int      outstanding;
	int      stall_cycles = 0;
	int      idle_pct     = 0;

	always #6 clk = ~clk;

	cooperative_task_scheduler dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.item,
		.result,
		.strobe
	);

	task_table_checker table_check (
		.clk,
		.arst_n,
		.start,
		.busy,
		.item,
		.result,
		.strobe,
		.errors (mismatches),
		.pending(outstanding)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic cmd_t junk(input logic [1:0] op);
		cmd_t w;
		w.command       = op;
		w.task_tag      = 8'($urandom);
		w.start_delay   = 24'($urandom);
		w.repeat_period = 24'($urandom);
		w.slot          = 3'($urandom);
		return w;
	endfunction

	function automatic logic [23:0] pick_delay();
		int r;
		r = $urandom_range(99, 0);
		if (r < 10)
			return 24'($urandom);
		if (r < 45)
			return 24'd0;
		return 24'($urandom_range(5, 1));
	endfunction

	function automatic logic [23:0] pick_period();
		int r;
		r = $urandom_range(99, 0);
		if (r < 10)
			return 24'($urandom);
		if (r < 40)
			return 24'd0;
		return 24'($urandom_range(6, 1));
	endfunction

	// hold start until the word is taken
	task automatic issue(input cmd_t w);
		while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic add_task(input logic [7:0] tag, input logic [23:0] dly,
	                        input logic [23:0] per);
		cmd_t w;
		w               = junk(CMD_ADD);
		w.task_tag      = tag;
		w.start_delay   = dly;
		w.repeat_period = per;
		issue(w);
	endtask

	task automatic drop_slot(input logic [2:0] s);
		cmd_t w;
		w      = junk(CMD_DEL);
		w.slot = s;
		issue(w);
	endtask

	initial begin
		int pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		idle_pct = 28;
		issue(junk(CMD_DISP));
		drop_slot(3'd0);
		issue(junk(CMD_TICK));
		add_task(8'h00, 24'd0, 24'd0);
		add_task(8'hFF, 24'd0, 24'd0);
		add_task(8'h5A, 24'd0, 24'd1);
		add_task(8'h01, 24'd0, 24'hFFFFFF);
		add_task(8'h80, 24'd1, 24'd2);
		add_task(8'h7F, 24'd0, 24'd0);
		add_task(8'hC3, 24'd1, 24'd0);
		add_task(8'hA5, 24'hFFFFFF, 24'hFFFFFF);
		add_task(8'h99, 24'd0, 24'd3);
		drop_slot(3'd7);
		add_task(8'h3C, 24'd0, 24'd0);
		issue(junk(CMD_TICK));
		issue(junk(CMD_TICK));
		issue(junk(CMD_DISP));
		issue(junk(CMD_DISP));
		drop_slot(3'd7);
		drop_slot(3'd0);
		drop_slot(3'd1);
		issue(junk(CMD_TICK));
		issue(junk(CMD_DISP));

		for (int p = 0; p < 3; p++) begin
			idle_pct = (p == 0) ? 28 : (p == 1) ? 58 : 0;
			repeat (PHASE_WORDS) begin
				pick = $urandom_range(99, 0);
				if (pick < 35)
					issue(junk(CMD_TICK));
				else if (pick < 60)
					add_task(8'($urandom), pick_delay(), pick_period());
				else if (pick < 72)
					drop_slot(3'($urandom));
				else
					issue(junk(CMD_DISP));
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cts_pkg.sv
sv/cts_table.sv
sv/cts_ctrl.sv
sv/cooperative_task_scheduler.sv
bench/task_table_checker.sv
bench/tb.sv
